>>> rtl/qvr_pkg.sv
package qvr_pkg;

    localparam int QW    = 16;   // quaternion component
    localparam int VW    = 32;   // vector component
    localparam int PW    = 32;   // quaternion component product
    localparam int MW    = 34;   // rotation matrix entry
    localparam int DW    = 33;   // |q|^2
    localparam int SPLIT = 17;   // matrix entry split point for the multipliers
    localparam int PHW   = MW - SPLIT + VW;       // high partial product
    localparam int PLW   = SPLIT + 1 + VW;        // low partial product
    localparam int SW    = 67;   // signed row dot product
    localparam int MAGW  = 66;   // magnitude of the dot product
    localparam int QTW   = 32;   // quotient bits produced by the divider
    localparam int IDXW  = 2;

    localparam logic [IDXW-1:0] REG_QUAT_W = 2'd0;
    localparam logic [IDXW-1:0] REG_QUAT_X = 2'd1;
    localparam logic [IDXW-1:0] REG_QUAT_Y = 2'd2;
    localparam logic [IDXW-1:0] REG_QUAT_Z = 2'd3;

    localparam logic signed [QW-1:0] QUAT_W_RST = 16'sd16384;

    localparam logic signed [VW-1:0] ROT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VW-1:0] ROT_MIN = 32'sh8000_0000;

    typedef logic signed [MW-1:0] mat_ent_t;

    typedef struct packed {
        mat_ent_t [8:0]  m;
        logic [DW-1:0]   d;
        logic            zero;
    } qvr_mat_t;

    typedef struct packed {
        logic            neg;
        logic            ovf;
        logic [DW-1:0]   rem;
        logic [QTW-1:0]  lo;
    } qvr_row_t;

    typedef struct packed {
        logic            zero;
        logic [DW-1:0]   d;
        qvr_row_t [2:0]  row;
    } qvr_dot_t;

endpackage

>>> rtl/qvr_matrix.sv
module qvr_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [qvr_pkg::IDXW-1:0]      cfg_index,
    input  logic [qvr_pkg::QW-1:0]        cfg_data,
    output qvr_pkg::qvr_mat_t             mat
);

    logic signed [qvr_pkg::QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [qvr_pkg::QW-1:0] qw_next, qx_next, qy_next, qz_next;

    logic signed [qvr_pkg::PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qvr_pkg::PW-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;

    logic signed [qvr_pkg::MW-1:0] e_ww, e_xx, e_yy, e_zz;
    logic signed [qvr_pkg::MW-1:0] e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;

    qvr_pkg::qvr_mat_t mat_reg, mat_next;

    always_comb
    begin
        qw_next = qw_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        qz_next = qz_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                qvr_pkg::REG_QUAT_W: qw_next = cfg_data;
                qvr_pkg::REG_QUAT_X: qx_next = cfg_data;
                qvr_pkg::REG_QUAT_Y: qy_next = cfg_data;
                qvr_pkg::REG_QUAT_Z: qz_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg <= qvr_pkg::QUAT_W_RST;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end
        else
        begin
            qw_reg <= qw_next;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
        end
    end

    // Products and matrix reload every cycle; the matrix is fed by the product registers.
    always_ff @(posedge clk)
    begin
        ww_reg <= qw_reg * qw_reg;
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        wz_reg <= qw_reg * qz_reg;
        xz_reg <= qx_reg * qz_reg;
        wy_reg <= qw_reg * qy_reg;
        yz_reg <= qy_reg * qz_reg;
        wx_reg <= qw_reg * qx_reg;
    end

    always_comb
    begin
        e_ww = qvr_pkg::MW'(ww_reg);
        e_xx = qvr_pkg::MW'(xx_reg);
        e_yy = qvr_pkg::MW'(yy_reg);
        e_zz = qvr_pkg::MW'(zz_reg);
        e_xy = qvr_pkg::MW'(xy_reg);
        e_wz = qvr_pkg::MW'(wz_reg);
        e_xz = qvr_pkg::MW'(xz_reg);
        e_wy = qvr_pkg::MW'(wy_reg);
        e_yz = qvr_pkg::MW'(yz_reg);
        e_wx = qvr_pkg::MW'(wx_reg);

        mat_next.m[0] = e_ww + e_xx - e_yy - e_zz;
        mat_next.m[1] = (e_xy - e_wz) <<< 1;
        mat_next.m[2] = (e_xz + e_wy) <<< 1;
        mat_next.m[3] = (e_xy + e_wz) <<< 1;
        mat_next.m[4] = e_ww - e_xx + e_yy - e_zz;
        mat_next.m[5] = (e_yz - e_wx) <<< 1;
        mat_next.m[6] = (e_xz - e_wy) <<< 1;
        mat_next.m[7] = (e_yz + e_wx) <<< 1;
        mat_next.m[8] = e_ww - e_xx - e_yy + e_zz;
        mat_next.d = qvr_pkg::DW'($unsigned(ww_reg)) + qvr_pkg::DW'($unsigned(xx_reg))
                   + qvr_pkg::DW'($unsigned(yy_reg)) + qvr_pkg::DW'($unsigned(zz_reg));
        mat_next.zero = (ww_reg == '0) && (xx_reg == '0) && (yy_reg == '0) && (zz_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

>>> rtl/qvr_dot.sv
module qvr_dot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [qvr_pkg::VW-1:0] vec_x,
    input  logic signed [qvr_pkg::VW-1:0] vec_y,
    input  logic signed [qvr_pkg::VW-1:0] vec_z,
    input  qvr_pkg::qvr_mat_t             mat,
    output logic                          dot_valid,
    output qvr_pkg::qvr_dot_t             dot
);

    logic [4:0] vld_reg;

    logic signed [qvr_pkg::VW-1:0]  vec1_reg [3];
    logic signed [qvr_pkg::VW-1:0]  vec2_reg [3];
    logic signed [qvr_pkg::PHW-1:0] ph_reg [9];
    logic signed [qvr_pkg::PLW-1:0] pl_reg [9];
    logic signed [qvr_pkg::SW-1:0]  sum_reg [3];
    logic signed [qvr_pkg::SW-1:0]  sum_next [3];
    logic [qvr_pkg::DW-1:0]         d3_reg, d4_reg;
    logic                           z3_reg, z4_reg;
    qvr_pkg::qvr_dot_t              dot_reg, dot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    // Two idle stages let the matrix settle after a configuration write.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec1_reg[0] <= vec_x;
            vec1_reg[1] <= vec_y;
            vec1_reg[2] <= vec_z;
            vec2_reg    <= vec1_reg;
            d3_reg      <= mat.d;
            z3_reg      <= mat.zero;
            d4_reg      <= d3_reg;
            z4_reg      <= z3_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < 9; gi++)
        begin : g_mul
            localparam int COL = gi % 3;
            logic signed [qvr_pkg::MW-qvr_pkg::SPLIT-1:0] mh;
            logic signed [qvr_pkg::SPLIT:0]               ml;
            assign mh = $signed(mat.m[gi][qvr_pkg::MW-1:qvr_pkg::SPLIT]);
            assign ml = $signed({1'b0, mat.m[gi][qvr_pkg::SPLIT-1:0]});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ph_reg[gi] <= mh * vec2_reg[COL];
                    pl_reg[gi] <= ml * vec2_reg[COL];
                end
            end
        end

        for (gi = 0; gi < 3; gi++)
        begin : g_sum
            always_comb
            begin
                sum_next[gi] = '0;
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[gi] = sum_next[gi]
                                 + (qvr_pkg::SW'(ph_reg[3*gi+c]) <<< qvr_pkg::SPLIT)
                                 + qvr_pkg::SW'(pl_reg[3*gi+c]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    // Take magnitude and sign, and flag quotients that cannot fit in 32 bits.
    always_comb
    begin
        logic signed [qvr_pkg::SW-1:0] abs_v;
        logic [qvr_pkg::MAGW-1:0]      mag;
        dot_next.zero = z4_reg;
        dot_next.d    = d4_reg;
        for (int r = 0; r < 3; r++)
        begin
            abs_v = sum_reg[r][qvr_pkg::SW-1] ? -sum_reg[r] : sum_reg[r];
            mag   = abs_v[qvr_pkg::MAGW-1:0];
            dot_next.row[r].neg = sum_reg[r][qvr_pkg::SW-1];
            dot_next.row[r].ovf = mag[qvr_pkg::MAGW-1:qvr_pkg::QTW] >= {1'b0, d4_reg};
            dot_next.row[r].rem = mag[qvr_pkg::QTW+qvr_pkg::DW-1:qvr_pkg::QTW];
            dot_next.row[r].lo  = mag[qvr_pkg::QTW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dot_reg <= dot_next;
    end

    assign dot_valid = vld_reg[4];
    assign dot       = dot_reg;

endmodule

>>> rtl/qvr_div.sv
module qvr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          dot_valid,
    input  qvr_pkg::qvr_dot_t             dot,
    output logic                          out_valid,
    output logic signed [qvr_pkg::VW-1:0] rot_x,
    output logic signed [qvr_pkg::VW-1:0] rot_y,
    output logic signed [qvr_pkg::VW-1:0] rot_z,
    output logic                          zero_quat_error,
    output logic                          saturated
);

    localparam int N = qvr_pkg::QTW;

    qvr_pkg::qvr_dot_t     stg [N+1];
    qvr_pkg::qvr_dot_t     st_reg [N];
    logic [N-1:0]          qv [N+1][3];
    logic [N-1:0]          q_reg [N][3];
    logic [N:0]            vld;
    logic [N-1:0]          vld_reg;

    logic                          out_valid_reg;
    logic signed [qvr_pkg::VW-1:0] rot_reg [3];
    logic signed [qvr_pkg::VW-1:0] rot_next [3];
    logic                          zerr_reg, zerr_next;
    logic                          sat_reg, sat_next;

    assign stg[0] = dot;
    assign vld[0] = dot_valid;
    assign qv[0][0] = '0;
    assign qv[0][1] = '0;
    assign qv[0][2] = '0;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            qvr_pkg::qvr_dot_t step;
            logic [N-1:0]      qn [3];

            // One restoring step: shift in the next dividend bit, subtract when it fits.
            always_comb
            begin
                logic [qvr_pkg::DW:0] t;
                logic                 ge;
                step = stg[k];
                for (int r = 0; r < 3; r++)
                begin
                    t  = {stg[k].row[r].rem, stg[k].row[r].lo[N-1]};
                    ge = t >= {1'b0, stg[k].d};
                    step.row[r].rem = ge ? qvr_pkg::DW'(t - {1'b0, stg[k].d})
                                         : qvr_pkg::DW'(t);
                    step.row[r].lo  = {stg[k].row[r].lo[N-2:0], 1'b0};
                    qn[r] = {qv[k][r][N-2:0], ge};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= step;
                    q_reg[k]  <= qn;
                end
            end

            assign stg[k+1] = st_reg[k];
            assign qv[k+1]  = q_reg[k];
            assign vld[k+1] = vld_reg[k];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld[N-1:0];
    end

    // Clamp to the 32-bit range and apply the sign; a zero quaternion gives zeros, unsaturated.
    always_comb
    begin
        logic [N-1:0] q;
        sat_next  = 1'b0;
        zerr_next = stg[N].zero;
        for (int r = 0; r < 3; r++)
        begin
            q = qv[N][r];
            if (stg[N].row[r].neg)
            begin
                if (stg[N].row[r].ovf || q > N'(32'h8000_0000))
                begin
                    rot_next[r] = qvr_pkg::ROT_MIN;
                    sat_next    = 1'b1;
                end
                else
                    rot_next[r] = $signed(N'(0) - q);
            end
            else
            begin
                if (stg[N].row[r].ovf || q[N-1])
                begin
                    rot_next[r] = qvr_pkg::ROT_MAX;
                    sat_next    = 1'b1;
                end
                else
                    rot_next[r] = $signed(q);
            end
            if (stg[N].zero)
                rot_next[r] = '0;
        end
        if (stg[N].zero)
            sat_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            zerr_reg <= zerr_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rot_x           = rot_reg[0];
    assign rot_y           = rot_reg[1];
    assign rot_z           = rot_reg[2];
    assign zero_quat_error = zerr_reg;
    assign saturated       = sat_reg;

endmodule

>>> rtl/quaternion_vector_rotation_top.sv
// Rotates a stream of Q15.16 vectors by the Q1.14 quaternion held in four
// configuration registers: out = q * (0,v) * conj(q) / |q|^2, each component
// truncated toward zero and clamped to 32 bits.
// Input channel: in_valid / in_stall with vec_x, vec_y, vec_z. Output channel:
// out_valid / out_stall with rot_x, rot_y, rot_z, zero_quat_error, saturated.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 = w, 1 = x, 2 = y,
// 3 = z) and cfg_data; cfg_ready is always high. Write only while no word is
// in flight; the new quaternion is in effect for the next accepted word.
// Throughput: one word per cycle while the output is not stalled. From the
// accepting edge the word passes the idle stages, the multiply, sum and
// magnitude stages, the 32 one-bit-per-stage divider stages by |q|^2 and
// the clamp register before it appears on the output.
// A zero quaternion gives zero components with zero_quat_error set.
// Reset clears all valid bits and loads the identity quaternion (w = 1.0).
// While the output word is stalled the whole pipeline holds and in_stall is
// raised; nothing is dropped or repeated.
module quaternion_vector_rotation_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [qvr_pkg::VW-1:0] vec_x,
    input  logic signed [qvr_pkg::VW-1:0] vec_y,
    input  logic signed [qvr_pkg::VW-1:0] vec_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [qvr_pkg::VW-1:0] rot_x,
    output logic signed [qvr_pkg::VW-1:0] rot_y,
    output logic signed [qvr_pkg::VW-1:0] rot_z,
    output logic                          zero_quat_error,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qvr_pkg::IDXW-1:0]      cfg_index,
    input  logic [qvr_pkg::QW-1:0]        cfg_data
);

    logic              en;
    logic              dot_valid;
    qvr_pkg::qvr_mat_t mat;
    qvr_pkg::qvr_dot_t dot;

    // Advance the dot and divider stages unless the output word is held.
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    qvr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    qvr_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .mat       (mat),
        .dot_valid (dot_valid),
        .dot       (dot)
    );

    qvr_div u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .dot_valid       (dot_valid),
        .dot             (dot),
        .out_valid       (out_valid),
        .rot_x           (rot_x),
        .rot_y           (rot_y),
        .rot_z           (rot_z),
        .zero_quat_error (zero_quat_error),
        .saturated       (saturated)
    );

    a_zero_quat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_quat_error |->
            !saturated && rot_x == '0 && rot_y == '0 && rot_z == '0)
        else $error("zero quaternion word carries nonzero data");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            rot_x == qvr_pkg::ROT_MAX || rot_x == qvr_pkg::ROT_MIN ||
            rot_y == qvr_pkg::ROT_MAX || rot_y == qvr_pkg::ROT_MIN ||
            rot_z == qvr_pkg::ROT_MAX || rot_z == qvr_pkg::ROT_MIN)
        else $error("saturated flag without a clamped component");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while the pipeline is held");

endmodule
